// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL top level; they sample on clock and skip reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TKST_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication
`define TKST_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/tkst_pkg.sv =====
package tkst_pkg;

   // Table size and derived widths
   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths
   localparam int FUNC_W   = 2;
   localparam int ID_W     = 31;
   localparam int SCORE_W  = 16;
   localparam int TIME_W   = 16;
   localparam int RIDX_W   = 6;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int FILL_W   = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED   = 3'd0,
      ST_RAISED     = 3'd1,
      ST_REJECTED   = 3'd2,
      ST_READ_OK    = 3'd3,
      ST_READ_EMPTY = 3'd4,
      ST_CLEARED    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SEARCH,
      S_BUBBLE,
      S_PLACE,
      S_EMIT
   } state_type;

   // One table entry as stored in the memory
   typedef struct packed {
      logic [ID_W-1:0]           entry_id;
      logic signed [SCORE_W-1:0] entry_score;
      logic signed [TIME_W-1:0]  entry_time;
   } entry_type;

   // Controller to memory port
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   // Result fields other than the fill count
   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          position;
      logic [ID_W-1:0]           out_id;
      logic signed [SCORE_W-1:0] out_score;
      logic signed [TIME_W-1:0]  out_time;
   } res_type;

   // Controller status seen by the top level checks
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

// ===== src/tkst_req_if.sv =====
interface tkst_req_if;
   logic                               valid;
   logic                               ready;
   logic [tkst_pkg::FUNC_W-1:0]        func;
   logic [tkst_pkg::ID_W-1:0]          player_id;
   logic signed [tkst_pkg::SCORE_W-1:0] score;
   logic signed [tkst_pkg::TIME_W-1:0] finish_time;
   logic [tkst_pkg::RIDX_W-1:0]        read_index;

   modport source (output valid, func, player_id, score, finish_time, read_index,
                   input ready);
   modport sink (input valid, func, player_id, score, finish_time, read_index,
                 output ready);
endinterface

// ===== src/tkst_rsp_if.sv =====
interface tkst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tkst_pkg::STATUS_W-1:0]      status;
   logic [tkst_pkg::POS_W-1:0]         position;
   logic [tkst_pkg::ID_W-1:0]          out_id;
   logic signed [tkst_pkg::SCORE_W-1:0] out_score;
   logic signed [tkst_pkg::TIME_W-1:0] out_time;
   logic [tkst_pkg::FILL_W-1:0]        fill_count;

   modport source (output valid, status, position, out_id, out_score, out_time,
                   fill_count, input ready);
   modport sink (input valid, status, position, out_id, out_score, out_time,
                 fill_count, output ready);
endinterface

// ===== src/tkst_table_mem.sv =====
module tkst_table_mem (
   input  logic                   clock,
   input  tkst_pkg::mem_req_type  mem_req,
   output tkst_pkg::entry_type    rd_data
);
   import tkst_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tkst_ctrl.sv =====
module tkst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   tkst_req_if.sink             req_ch,
   tkst_rsp_if.source           rsp_ch,
   output tkst_pkg::mem_req_type mem_req,
   input  tkst_pkg::entry_type  rd_data,
   output tkst_pkg::stat_type   stat
);
   import tkst_pkg::*;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ID_W-1:0]           id_ff, id_in;
   logic signed [SCORE_W-1:0] sc_ff, sc_in;
   logic signed [TIME_W-1:0]  tm_ff, tm_in;
   logic [RIDX_W-1:0]         ri_ff, ri_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   status_type                status_ff, status_in;
   res_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   res_type                   rsp_ff, rsp_in;
   logic [FILL_W-1:0]         rsp_fill_ff, rsp_fill_in;

   entry_type                 req_entry;
   logic                      out_free;
   logic                      hit;
   logic                      last;
   logic                      front_keeps;
   logic                      start_go;
   logic [IDX_W-1:0]          start_pos;

   assign req_entry = '{entry_id: id_ff, entry_score: sc_ff, entry_time: tm_ff};
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Compare helpers on the entry read last cycle
   assign hit  = (rd_data.entry_id == id_ff);
   assign last = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == count_ff);
   // The stored entry stays ahead of the request on higher score, or tie and no later time
   assign front_keeps = (rd_data.entry_score > sc_ff) ||
                        ((rd_data.entry_score == sc_ff) && (rd_data.entry_time <= tm_ff));

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      sc_ff       <= sc_in;
      tm_ff       <= tm_in;
      ri_ff       <= ri_in;
      cmp_idx_ff  <= cmp_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   // Sequencer: search, then bubble the request entry toward the front.
   // Bubble writes land at pos while reads go to pos-2, so no overlap on one entry.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      id_in        = id_ff;
      sc_in        = sc_ff;
      tm_in        = tm_ff;
      ri_in        = ri_ff;
      cmp_idx_in   = cmp_idx_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      start_go     = 1'b0;
      start_pos    = '0;
      mem_req      = '{we: 1'b0, waddr: '0, wdata: req_entry, raddr: '0};
      req_ch.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               id_in = req_ch.player_id;
               sc_in = req_ch.score;
               tm_in = req_ch.finish_time;
               ri_in = req_ch.read_index;
               case (func_type'(req_ch.func))
                  FUNC_READ: begin
                     mem_req.raddr = IDX_W'(req_ch.read_index);
                     state_in      = S_READ;
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                     res_in   = '{status: ST_CLEARED, position: '0, out_id: '0,
                                  out_score: '0, out_time: '0};
                     state_in = S_EMIT;
                  end
                  FUNC_UPDATE: begin
                     if (count_ff == '0) begin
                        count_in  = CNT_W'(1);
                        status_in = ST_INSERTED;
                        pos_in    = '0;
                        state_in  = S_PLACE;
                     end else begin
                        mem_req.raddr = '0;
                        cmp_idx_in    = '0;
                        state_in      = S_SEARCH;
                     end
                  end
                  default: begin
                     res_in   = '{status: ST_REJECTED, position: '0, out_id: '0,
                                  out_score: '0, out_time: '0};
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_READ: begin
            if (int'(ri_ff) < int'(count_ff)) begin
               res_in = '{status: ST_READ_OK, position: POS_W'(ri_ff),
                          out_id: rd_data.entry_id, out_score: rd_data.entry_score,
                          out_time: rd_data.entry_time};
            end else begin
               res_in = '{status: ST_READ_EMPTY, position: POS_W'(ri_ff), out_id: '0,
                          out_score: '0, out_time: '0};
            end
            state_in = S_EMIT;
         end

         S_SEARCH: begin
            if (hit) begin
               if (sc_ff <= rd_data.entry_score) begin
                  res_in   = '{status: ST_REJECTED, position: '0, out_id: id_ff,
                               out_score: sc_ff, out_time: tm_ff};
                  state_in = S_EMIT;
               end else begin
                  status_in = ST_RAISED;
                  start_go  = 1'b1;
                  start_pos = cmp_idx_ff;
               end
            end else if (last) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  status_in = ST_INSERTED;
                  count_in  = count_ff + CNT_W'(1);
                  start_go  = 1'b1;
                  start_pos = IDX_W'(count_ff);
               end else if (front_keeps) begin
                  // Full table and the last entry still ranks ahead
                  res_in   = '{status: ST_REJECTED, position: '0, out_id: id_ff,
                               out_score: sc_ff, out_time: tm_ff};
                  state_in = S_EMIT;
               end else begin
                  status_in = ST_INSERTED;
                  start_go  = 1'b1;
                  start_pos = IDX_W'(DEPTH - 1);
               end
            end else begin
               cmp_idx_in    = cmp_idx_ff + IDX_W'(1);
               mem_req.raddr = cmp_idx_ff + IDX_W'(1);
            end
         end

         S_BUBBLE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (front_keeps) begin
               mem_req.wdata = req_entry;
               res_in   = '{status: status_ff, position: POS_W'(pos_ff), out_id: id_ff,
                            out_score: sc_ff, out_time: tm_ff};
               state_in = S_EMIT;
            end else begin
               // Front entry drops back one place
               mem_req.wdata = rd_data;
               pos_in        = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_req.raddr = pos_ff - IDX_W'(2);
               end
            end
         end

         S_PLACE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            mem_req.wdata = req_entry;
            res_in   = '{status: status_ff, position: POS_W'(pos_ff), out_id: id_ff,
                         out_score: sc_ff, out_time: tm_ff};
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_fill_in  = FILL_W'(count_ff);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Enter the bubble walk, or place at once at the front
      if (start_go) begin
         pos_in = start_pos;
         if (start_pos == '0) begin
            state_in = S_PLACE;
         end else begin
            mem_req.raddr = start_pos - IDX_W'(1);
            state_in      = S_BUBBLE;
         end
      end
   end

   // Result register drives the response channel
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = STATUS_W'(rsp_ff.status);
   assign rsp_ch.position   = rsp_ff.position;
   assign rsp_ch.out_id     = rsp_ff.out_id;
   assign rsp_ch.out_score  = rsp_ff.out_score;
   assign rsp_ch.out_time   = rsp_ff.out_time;
   assign rsp_ch.fill_count = rsp_fill_ff;

   assign stat = '{busy: (state_ff != S_IDLE), count: count_ff};

endmodule

// ===== src/top_k_score_table_unit.sv =====
// An update scans the table for the id (up to 64 entries), then moves the entry
//   forward (up to 63 places).
// One request is handled at a time; the table memory (one read port, one write port)
//   sets the scan and move rate.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, active high) empties the table and drops any pending result.
`include "assert_macros.svh"

module top_k_score_table_unit (
   input logic        clock,
   input logic        reset,
   tkst_req_if.sink   req_ch,
   tkst_rsp_if.source rsp_ch
);
   import tkst_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   stat_type    stat;
   logic        req_fire;
   logic        read_ok_rsp;
   logic        read_in_fill;

   tkst_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_req (mem_req),
      .rd_data (rd_data),
      .stat    (stat)
   );

   tkst_table_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Check terms
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign read_ok_rsp  = rsp_ch.valid && (rsp_ch.status == ST_READ_OK);
   assign read_in_fill = FILL_W'(rsp_ch.position) < rsp_ch.fill_count;

   // Checks
   `TKST_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(DEPTH), "fill count above depth")
   `TKST_ASSERT_NEXT(a_busy_after_req, req_fire, stat.busy, "request taken but controller idle")
   `TKST_ASSERT_NOW(a_read_in_fill, read_ok_rsp, read_in_fill, "read ok beyond fill")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tkst_pkg::*;

   localparam int STALL_LIMIT  = 5000;   // cycles with no handshake on either side
   localparam int PHASE_ITEMS  = 350;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;

   // One update, read, clear or unused request
   typedef struct {
      func_type                  func;
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic signed [TIME_W-1:0]  ftime;
      logic [RIDX_W-1:0]         ridx;
   } score_req_type;

   // One leaderboard response
   typedef struct {
      status_type                status;
      logic [POS_W-1:0]          position;
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic signed [TIME_W-1:0]  ftime;
      logic [FILL_W-1:0]         fill;
   } standing_type;

   // Directed row: request plus an optional hand-written response
   typedef struct {
      score_req_type rq;
      bit            typed;
      standing_type  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   tkst_req_if req_if ();
   tkst_rsp_if rsp_if ();

   top_k_score_table_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Leaderboard mirror
   logic [ID_W-1:0]           board_id    [DEPTH];
   logic signed [SCORE_W-1:0] board_score [DEPTH];
   logic signed [TIME_W-1:0]  board_time  [DEPTH];
   int                        board_fill;

   standing_type   pending_standings [$];
   script_row_type script_rows [$];
   standing_type   oldest;
   int             mismatches;
   int             send_gap_pct;
   int             recv_gap_pct;
   bit             hold_request;
   int             hold_left;
   int             quiet_cycles;

   // Move an entry forward while it outranks the one in front
   function automatic int climb(input int start);
      int                        pos;
      int                        f;
      bit                        moving;
      logic [ID_W-1:0]           ti;
      logic signed [SCORE_W-1:0] ts;
      logic signed [TIME_W-1:0]  tt;
      pos = start;
      moving = 1'b1;
      while (moving && pos > 0) begin
         f = pos - 1;
         if (board_score[f] > board_score[pos] ||
             (board_score[f] == board_score[pos] && board_time[f] <= board_time[pos])) begin
            moving = 1'b0;
         end else begin
            ti = board_id[f];
            ts = board_score[f];
            tt = board_time[f];
            board_id[f]      = board_id[pos];
            board_score[f]   = board_score[pos];
            board_time[f]    = board_time[pos];
            board_id[pos]    = ti;
            board_score[pos] = ts;
            board_time[pos]  = tt;
            pos = f;
         end
      end
      return pos;
   endfunction

   // Apply one request to the mirror and return the response it should produce
   function automatic standing_type rank_request(input score_req_type rq);
      standing_type r;
      int           hit;
      int           pos;
      bit           take;
      r.status   = ST_REJECTED;
      r.position = '0;
      r.id       = '0;
      r.score    = '0;
      r.ftime    = '0;
      hit  = -1;
      take = 1'b1;
      case (rq.func)
         FUNC_READ: begin
            r.position = rq.ridx;
            if (rq.ridx < board_fill) begin
               r.status = ST_READ_OK;
               r.id     = board_id[rq.ridx];
               r.score  = board_score[rq.ridx];
               r.ftime  = board_time[rq.ridx];
            end else begin
               r.status = ST_READ_EMPTY;
            end
         end
         FUNC_CLEAR: begin
            board_fill = 0;
            r.status   = ST_CLEARED;
         end
         FUNC_UPDATE: begin
            r.id    = rq.id;
            r.score = rq.score;
            r.ftime = rq.ftime;
            for (int i = 0; i < board_fill; i++)
               if (hit < 0 && board_id[i] == rq.id) hit = i;
            if (hit >= 0) begin
               // known id: only a strictly higher score counts
               if (rq.score > board_score[hit]) begin
                  board_score[hit] = rq.score;
                  board_time[hit]  = rq.ftime;
                  r.status   = ST_RAISED;
                  r.position = POS_W'(climb(hit));
               end
            end else begin
               if (board_fill < DEPTH) begin
                  pos = board_fill;
                  board_fill++;
               end else begin
                  // full table: must strictly outrank the last entry
                  pos = DEPTH - 1;
                  if (board_score[pos] > rq.score ||
                      (board_score[pos] == rq.score && board_time[pos] <= rq.ftime))
                     take = 1'b0;
               end
               if (take) begin
                  board_id[pos]    = rq.id;
                  board_score[pos] = rq.score;
                  board_time[pos]  = rq.ftime;
                  r.status   = ST_INSERTED;
                  r.position = POS_W'(climb(pos));
               end
            end
         end
         default: ;
      endcase
      r.fill = FILL_W'(board_fill);
      return r;
   endfunction

   task automatic add_row(input func_type f, input logic [ID_W-1:0] id, input int sc,
                          input int tm, input int ix, input bit typed,
                          input status_type st, input int pos, input logic [ID_W-1:0] oid,
                          input int osc, input int otm, input int fill);
      script_row_type row;
      row.rq.func        = f;
      row.rq.id          = id;
      row.rq.score       = SCORE_W'(sc);
      row.rq.ftime       = TIME_W'(tm);
      row.rq.ridx        = RIDX_W'(ix);
      row.typed          = typed;
      row.want.status    = st;
      row.want.position  = POS_W'(pos);
      row.want.id        = oid;
      row.want.score     = SCORE_W'(osc);
      row.want.ftime     = TIME_W'(otm);
      row.want.fill      = FILL_W'(fill);
      script_rows.push_back(row);
   endtask

   // Mostly updates on a pool of 128 ids, twice the table depth, so it fills up
   function automatic score_req_type random_request();
      score_req_type rq;
      int            pick;
      pick = $urandom_range(999);
      if (pick < 740)      rq.func = FUNC_UPDATE;
      else if (pick < 945) rq.func = FUNC_READ;
      else if (pick < 950) rq.func = FUNC_CLEAR;
      else                 rq.func = FUNC_NONE;
      rq.id = ($urandom_range(9) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(127));
      case ($urandom_range(9))
         0:          rq.score = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1, 2, 3, 4: rq.score = SCORE_W'($urandom());
         default:    rq.score = SCORE_W'(int'($urandom_range(40)) - 20);
      endcase
      case ($urandom_range(9))
         0:          rq.ftime = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1, 2, 3, 4: rq.ftime = TIME_W'($urandom());
         default:    rq.ftime = TIME_W'(int'($urandom_range(8)) - 4);
      endcase
      if (board_fill > 0 && $urandom_range(3) != 0)
         rq.ridx = RIDX_W'($urandom_range(board_fill - 1));
      else
         rq.ridx = RIDX_W'($urandom_range(63));
      return rq;
   endfunction

   // Offer one request; called and returning at a falling edge
   task automatic push_request(input script_row_type row);
      standing_type got;
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= row.rq.func;
      req_if.player_id   <= row.rq.id;
      req_if.score       <= row.rq.score;
      req_if.finish_time <= row.rq.ftime;
      req_if.read_index  <= row.rq.ridx;
      do @(posedge clock); while (!req_if.ready);
      got = rank_request(row.rq);
      pending_standings.push_back(row.typed ? row.want : got);
      @(negedge clock);
   endtask

   function automatic void check_field(input string what, input logic signed [63:0] want_v,
                                       input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_standings.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d id %0d",
                     $time, rsp_if.status, rsp_if.out_id);
            mismatches++;
         end else begin
            oldest = pending_standings.pop_front();
            check_field("status", oldest.status, rsp_if.status);
            check_field("position", oldest.position, rsp_if.position);
            check_field("out_id", oldest.id, rsp_if.out_id);
            check_field("out_score", oldest.score, rsp_if.out_score);
            check_field("out_time", oldest.ftime, rsp_if.out_time);
            check_field("fill_count", oldest.fill, rsp_if.fill_count);
         end
      end
   end

   // Response side back-pressure, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("top_k_score_table_unit verification failed");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      int             counted;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_UPDATE;
      req_if.player_id   = '0;
      req_if.score       = '0;
      req_if.finish_time = '0;
      req_if.read_index  = '0;
      rsp_if.ready       = 1'b0;
      board_fill         = 0;
      mismatches         = 0;
      send_gap_pct       = 0;
      recv_gap_pct       = 0;
      hold_request       = 1'b0;
      hold_left          = 0;
      quiet_cycles       = 0;

      // Directed table: reads on an empty board, extremes, ties, rejects, clear
      add_row(FUNC_READ,   0, 0, 0, 0,  1, ST_READ_EMPTY, 0,  0, 0, 0, 0);
      add_row(FUNC_READ,   0, 0, 0, 63, 1, ST_READ_EMPTY, 63, 0, 0, 0, 0);
      add_row(FUNC_NONE,   31'h7FFFFFFF, -1, -1, 63, 1, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 31'h7FFFFFFF, 32767, -32768, 0, 1, ST_INSERTED, 0,
              31'h7FFFFFFF, 32767, -32768, 1);
      add_row(FUNC_UPDATE, 0, -32768, 32767, 0, 1, ST_INSERTED, 1, 0, -32768, 32767, 2);
      add_row(FUNC_UPDATE, 7, 100, 5, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 8, 100, 3, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 9, 100, 5, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 7, 100, 0, 0, 1, ST_REJECTED, 0, 7, 100, 0, 5);
      add_row(FUNC_UPDATE, 0, 200, 1, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 0, 32767, -32768, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_READ,   0, 0, 0, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_READ,   0, 0, 0, 4, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_READ,   0, 0, 0, 5, 1, ST_READ_EMPTY, 5, 0, 0, 0, 5);
      add_row(FUNC_CLEAR,  31'h2AAAAAAA, 21845, -21846, 42, 1, ST_CLEARED, 0, 0, 0, 0, 0);
      add_row(FUNC_READ,   0, 0, 0, 0, 1, ST_READ_EMPTY, 0, 0, 0, 0, 0);
      add_row(FUNC_NONE,   31'h55555555, -21846, 21845, 21, 1, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 31'h2AAAAAAA, -5, 0, 0, 1, ST_INSERTED, 0, 31'h2AAAAAAA, -5, 0, 1);
      add_row(FUNC_UPDATE, 31'h55555555, -5, -1, 0, 0, ST_REJECTED, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 31'h2AAAAAAA, -6, 0, 0, 1, ST_REJECTED, 0, 31'h2AAAAAAA, -6, 0, 2);
      add_row(FUNC_READ,   0, 0, 0, 1, 0, ST_REJECTED, 0, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script_rows[i]) push_request(script_rows[i]);

      // Random phases: receiver gaps, then sender gaps, then full rate with a hold-off
      for (int phase = 0; phase < 3; phase++) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         send_gap_pct = (phase == 0) ? 17 : (phase == 1) ? 75 : 0;
         recv_gap_pct = (phase == 0) ? 75 : (phase == 1) ? 17 : 0;
         if (phase == 2) hold_request = 1'b1;
         @(negedge clock);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            row.rq    = random_request();
            row.typed = 1'b0;
            push_request(row);
            counted++;
         end
      end
      req_if.valid <= 1'b0;

      // Drain, then give the block time to show any stray response
      while (pending_standings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("top_k_score_table_unit verification clean");
      end else begin
         $display("top_k_score_table_unit verification failed");
      end
      $finish;
   end

endmodule
